@@ sv/bsm_pkg.sv @@
// bsm_pkg: shared widths and defaults for the bounding-sphere union block.
// No dependencies.
`default_nettype none
package bsm_pkg;
	localparam int CoordW = 32;
	localparam int RadW   = 31;
	localparam int FractionBitsDef = 16;
	localparam int DeltaW = 33;	// coordinate difference
	localparam int SumW   = 68;	// sum of three squares
	localparam int DistW  = 35;	// floor sqrt of SumW bits
endpackage
`default_nettype wire

@@ sv/bsm_sqrt.sv @@
// bsm_sqrt: restoring square root, one result bit per cycle.
// Depends on bsm_pkg.
`default_nettype none
module bsm_sqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [bsm_pkg::SumW-1:0]  radicand,
	output logic                           done,
	output logic [bsm_pkg::DistW-1:0]      root
);
	import bsm_pkg::*;
	logic [SumW-1:0]  rem_q;
	logic [SumW-1:0]  root_q;
	logic [SumW-1:0]  bit_q;
	logic             busy_q;
	logic [SumW-1:0]  trial;
	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (bit_q[1:0] != 2'b00 || bit_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// classic digit-by-digit: root shifts right by one each step, bit walks down by two
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= radicand;
			root_q <= '0;
			bit_q  <= {2'b01, {(SumW-2){1'b0}}};
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (trial + bit_q) >> 1;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
	assign root = root_q[DistW-1:0];
endmodule
`default_nettype wire

@@ sv/bsm_div.sv @@
// bsm_div: restoring divider, one quotient bit per cycle, 100-bit dividend.
// Depends on bsm_pkg.
`default_nettype none
module bsm_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [99:0]               dividend,
	input  wire logic [bsm_pkg::DistW:0]   divisor,
	output logic                           done,
	output logic [bsm_pkg::DeltaW-1:0]     quotient
);
	import bsm_pkg::*;
	localparam int NW = 100;
	logic [NW-1:0]   num_q;
	logic [DistW+1:0] rem_q;
	logic [6:0]      cnt_q;
	logic            busy_q;
	logic [DistW+1:0] sh;
	assign sh = {rem_q[DistW:0], num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (sh >= {1'b0, divisor}) begin
				rem_q <= sh - {1'b0, divisor};
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end
	assign quotient = num_q[DeltaW-1:0];
endmodule
`default_nettype wire

@@ sv/bounding_sphere_merge_top.sv @@
// bounding_sphere_merge_top: incremental bounding-sphere union.
// Skip, copy and start go straight to the output state; otherwise three squares are summed
// and square-rooted to test containment, and on growth three divides (one per axis) follow.
// A new sphere is taken only in idle; in_ready low while busy.
// One output register holds the result; a full register stalls the sequencer.
// arst_n clears held sphere. Depends on bsm_pkg, bsm_sqrt, bsm_div.
`default_nettype none
module bounding_sphere_merge_top #(
	parameter int FRACTION_BITS = bsm_pkg::FractionBitsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        start_req,
	input  wire logic signed [31:0] center_x,
	input  wire logic signed [31:0] center_y,
	input  wire logic signed [31:0] center_z,
	input  wire logic [30:0] sphere_radius,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [30:0]      out_radius,
	output logic             out_valid
);
	import bsm_pkg::*;
	// Raw integer arithmetic: the fraction width never changes the maths.
	localparam logic [4:0] FracTag = 5'(FRACTION_BITS);

	localparam logic [2:0] S_IDLE = 3'd0, S_SQ = 3'd1, S_SQRT = 3'd2,
		S_DIV = 3'd3, S_OUT = 3'd4, S_SQW = 3'd5;
	logic [2:0] st_q;
	logic [1:0] ax_q;	// axis index for squares/divides

	logic signed [31:0] hx_q, hy_q, hz_q, nx_q, ny_q, nz_q;
	logic [30:0] hr_q, nr_q;
	logic hv_q;
	// result register, loaded from the held sphere
	logic signed [31:0] ox_q, oy_q, oz_q;
	logic [30:0] orad_q;
	logic ov_q;
	logic signed [DeltaW-1:0] d_q [3];
	logic [SumW-1:0] sum_q;
	logic [DistW-1:0] dist_q;
	logic [DistW:0] k_q;
	logic [66:0] sqp_q;	// registered product

	logic signed [DeltaW-1:0] dsel;
	logic [DeltaW-1:0] dmag;
	assign dsel = d_q[ax_q];
	assign dmag = dsel[DeltaW-1] ? DeltaW'(-dsel) : DeltaW'(dsel);
	// shared multiplier: squares and k*|delta|
	logic [DistW:0] mb;
	logic [66:0] prod;
	assign mb = (st_q == S_DIV) ? k_q : (DistW+1)'(dmag);
	assign prod = 67'(dmag) * 67'(mb);

	logic sq_go, sq_done, dv_go, dv_done;
	logic [DistW-1:0] root;
	logic [DeltaW-1:0] quo;
	logic dv_wait_q;
	logic sqp_ok_q;
	bsm_sqrt u_sqrt (.clk, .arst_n, .start(sq_go), .radicand(sum_q),
		.done(sq_done), .root);
	bsm_div u_div (.clk, .arst_n, .start(dv_go), .dividend({33'd0, sqp_q}),
		.divisor({dist_q, 1'b0}), .done(dv_done), .quotient(quo));

	assign in_ready = (st_q == S_IDLE);
	assign sq_go = (st_q == S_SQW);
	assign dv_go = (st_q == S_DIV) && !dv_wait_q && sqp_ok_q;

	logic [DistW+1:0] dhr, dnr, rsum;
	assign dhr = (DistW+2)'(root) + (DistW+2)'(hr_q);
	assign dnr = (DistW+2)'(root) + (DistW+2)'(nr_q);
	assign rsum = dhr + (DistW+2)'(nr_q);

	logic signed [31:0] hsel, nsum;
	assign hsel = (ax_q == 2'd0) ? hx_q : (ax_q == 2'd1) ? hy_q : hz_q;
	assign nsum = dsel[DeltaW-1] ? hsel - 32'(quo) : hsel + 32'(quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; ax_q <= '0; res_valid <= 1'b0;
			hx_q <= '0; hy_q <= '0; hz_q <= '0; hr_q <= '0; hv_q <= 1'b0;
			ox_q <= '0; oy_q <= '0; oz_q <= '0; orad_q <= '0; ov_q <= 1'b0;
			nx_q <= '0; ny_q <= '0; nz_q <= '0; nr_q <= '0;
			d_q[0] <= '0; d_q[1] <= '0; d_q[2] <= '0;
			sum_q <= '0; dist_q <= '0; k_q <= '0; sqp_q <= '0;
			dv_wait_q <= 1'b0; sqp_ok_q <= 1'b0;
		end else begin
			// result register: load when free or being emptied this cycle
			if (st_q == S_OUT && (!res_valid || res_ready)) begin
				res_valid <= 1'b1;
				ox_q <= hx_q; oy_q <= hy_q; oz_q <= hz_q;
				orad_q <= hr_q; ov_q <= hv_q;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: if (in_valid && in_ready) begin
					nx_q <= center_x; ny_q <= center_y; nz_q <= center_z;
					nr_q <= sphere_radius;
					if (sphere_radius == '0) begin
						if (start_req) begin
							hx_q <= '0; hy_q <= '0; hz_q <= '0; hr_q <= '0; hv_q <= 1'b0;
						end
						st_q <= S_OUT;
					end else if (start_req || !hv_q) begin
						hx_q <= center_x; hy_q <= center_y; hz_q <= center_z;
						hr_q <= sphere_radius; hv_q <= 1'b1;
						st_q <= S_OUT;
					end else begin
						d_q[0] <= DeltaW'(center_x) - DeltaW'(hx_q);
						d_q[1] <= DeltaW'(center_y) - DeltaW'(hy_q);
						d_q[2] <= DeltaW'(center_z) - DeltaW'(hz_q);
						sum_q <= '0; ax_q <= '0; st_q <= S_SQ;
					end
				end
				S_SQ: begin
					sum_q <= sum_q + SumW'(prod);
					if (ax_q == 2'd2) begin ax_q <= '0; st_q <= S_SQW; end
					else ax_q <= ax_q + 2'd1;
				end
				S_SQW: st_q <= S_SQRT;
				S_SQRT: if (sq_done) begin
					dist_q <= root;
					if ((DistW+2)'(nr_q) >= dhr) begin
						hx_q <= nx_q; hy_q <= ny_q; hz_q <= nz_q; hr_q <= nr_q;
						st_q <= S_OUT;
					end else if ((DistW+2)'(hr_q) >= dnr) begin
						st_q <= S_OUT;
					end else begin
						k_q <= (DistW+1)'(dnr - (DistW+2)'(hr_q));
						hr_q <= (rsum[DistW+1:1] > (DistW+1)'(31'h7FFF_FFFF)) ?
							31'h7FFF_FFFF : 31'(rsum[DistW+1:1]);
						ax_q <= '0; sqp_ok_q <= 1'b0; dv_wait_q <= 1'b0;
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!sqp_ok_q) begin
						sqp_q <= prod; sqp_ok_q <= 1'b1;
					end else if (!dv_wait_q) dv_wait_q <= 1'b1;
					else if (dv_done) begin
						unique case (ax_q)
							2'd0: hx_q <= nsum;
							2'd1: hy_q <= nsum;
							default: hz_q <= nsum;
						endcase
						dv_wait_q <= 1'b0; sqp_ok_q <= 1'b0;
						if (ax_q == 2'd2) st_q <= S_OUT;
						else ax_q <= ax_q + 2'd1;
					end
				end
				S_OUT: if (!res_valid || res_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
	assign out_x = ox_q; assign out_y = oy_q; assign out_z = oz_q;
	assign out_radius = orad_q; assign out_valid = ov_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> st_q == S_IDLE) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid) else $error("result lost");
	a_tag: assert property (@(posedge clk) FracTag <= 5'd30)
		else $error("bad fraction width");
endmodule
`default_nettype wire

@@ tb/bounding_sphere_merge_top_tb.sv @@
// Self-checking testbench for bounding_sphere_merge_top: directed table, then random spheres.
// Expected spheres come from an in-bench predictor of the union arithmetic.
// Depends on bsm_pkg and the bounding_sphere_merge_top RTL.
`default_nettype none
module bounding_sphere_merge_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsm_pkg::*;

	// one input sphere, and the held sphere reported back
	typedef struct packed {
		logic                     start;
		logic signed [CoordW-1:0] cx;
		logic signed [CoordW-1:0] cy;
		logic signed [CoordW-1:0] cz;
		logic [RadW-1:0]          rad;
	} sphere_t;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
		logic [RadW-1:0]          r;
		logic                     v;
	} held_t;

	// directed row: the sphere, whether its result is typed in, and that result
	typedef struct {
		sphere_t s;
		bit      fixed;
		held_t   res;
	} row_t;

	localparam logic [RadW-1:0] RMAX = {RadW{1'b1}};
	localparam logic signed [CoordW-1:0] CMAX = 32'sh7fff_ffff;
	localparam logic signed [CoordW-1:0] CMIN = 32'sh8000_0000;
	localparam int PH_FREE = 0, PH_SEND = 1, PH_RECV = 2, PH_BOTH = 3, PH_HOLD = 4;

	logic clk, arst_n;
	logic in_valid, in_ready, start_req;
	logic signed [31:0] center_x, center_y, center_z;
	logic [30:0] sphere_radius;
	logic res_valid, res_ready;
	logic signed [31:0] out_x, out_y, out_z;
	logic [30:0] out_radius;
	logic out_valid;

	bounding_sphere_merge_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_req(start_req), .center_x(center_x), .center_y(center_y),
		.center_z(center_z), .sphere_radius(sphere_radius),
		.res_valid(res_valid), .res_ready(res_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.out_radius(out_radius), .out_valid(out_valid)
	);

	// predictor copy of the held sphere
	held_t  union_held;
	held_t  expected_spheres[$];
	int     errors;
	int     phase;
	int     hold_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// runaway guard: generous against ~1400 items
	initial begin
		#200ms;
		$display("DONE: errors detected");
		$finish;
	end

	// floor sqrt of a 68-bit sum, bit by bit from the top
	function automatic logic [DistW-1:0] sqrt_floor(input logic [SumW-1:0] s);
		logic [DistW-1:0] root;
		logic [DistW-1:0] cand;
		root = '0;
		for (int b = DistW - 1; b >= 0; b--) begin
			cand = root | (35'd1 << b);
			if ({35'd0, cand} * {35'd0, cand} <= {2'd0, s})
				root = cand;
		end
		return root;
	endfunction

	// move one coordinate along delta by |delta|*k / (2*dist_v), magnitude truncated
	function automatic logic signed [CoordW-1:0] move_coord(
			input logic signed [CoordW-1:0] h, input logic signed [DeltaW-1:0] d,
			input logic [63:0] k, input logic [63:0] dist_v);
		logic [DeltaW-1:0] m;
		logic [127:0] q;
		logic signed [63:0] nv;
		m = d < 0 ? -d : d;
		q = ({95'd0, m} * {64'd0, k}) / {63'd0, dist_v, 1'b0};
		nv = d < 0 ? 64'(h) - 64'(q) : 64'(h) + 64'(q);
		return nv[CoordW-1:0];
	endfunction

	// fold one sphere into the held one and return what the block reports
	function automatic held_t merge_sphere(input sphere_t s);
		logic signed [DeltaW-1:0] dx, dy, dz;
		logic [SumW-1:0] sq;
		logic [63:0] dist_v, k, r;
		if (s.start)
			union_held = '0;
		if (s.rad != 0) begin
			if (!union_held.v) begin
				union_held = '{s.cx, s.cy, s.cz, s.rad, 1'b1};
			end else begin
				dx = DeltaW'(s.cx) - DeltaW'(union_held.x);
				dy = DeltaW'(s.cy) - DeltaW'(union_held.y);
				dz = DeltaW'(s.cz) - DeltaW'(union_held.z);
				sq = SumW'(dx) * SumW'(dx) + SumW'(dy) * SumW'(dy) + SumW'(dz) * SumW'(dz);
				dist_v = 64'(sqrt_floor(sq));
				if (dist_v + union_held.r <= 64'(s.rad)) begin
					union_held = '{s.cx, s.cy, s.cz, s.rad, 1'b1};
				end else if (!(dist_v + s.rad <= 64'(union_held.r))) begin
					k = dist_v + s.rad - union_held.r;
					r = (64'(union_held.r) + s.rad + dist_v) >> 1;
					union_held.x = move_coord(union_held.x, dx, k, dist_v);
					union_held.y = move_coord(union_held.y, dy, k, dist_v);
					union_held.z = move_coord(union_held.z, dz, k, dist_v);
					union_held.r = r > 64'(RMAX) ? RMAX : r[RadW-1:0];
				end
			end
		end
		return union_held;
	endfunction

	// idle chance in percent for the current phase
	function automatic bit idle_now(input bit sender);
		int pct;
		case (phase)
			PH_SEND: pct = sender ? 46 : 0;
			PH_RECV: pct = sender ? 0 : 46;
			PH_BOTH: pct = 30;
			default: pct = 0;
		endcase
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic logic signed [31:0] rand_coord(input int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(2000, 0)) - 1000;
			default: return $signed($urandom_range(32'h0030_0000, 0)) - 32'sh0018_0000;
		endcase
	endfunction

	// offer one transaction; fields settle at the falling edge, accepted on a rising one.
	// valid is left high on return, the next offer or an idle gap replaces it
	task automatic send_sphere(input sphere_t s, input bit fixed, input held_t res);
		while (idle_now(1'b1)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		start_req     <= s.start;
		center_x      <= s.cx;
		center_y      <= s.cy;
		center_z      <= s.cz;
		sphere_radius <= s.rad;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// predict at acceptance so the queue order matches the block's
		if (fixed) begin
			void'(merge_sphere(s));
			expected_spheres.push_back(res);
		end else begin
			expected_spheres.push_back(merge_sphere(s));
		end
		@(negedge clk);
	endtask

	function automatic sphere_t rand_sphere(input bit start);
		sphere_t s;
		int mode;
		mode = $urandom_range(9, 0);
		s.start = start;
		s.cx = rand_coord(mode < 2 ? 0 : (mode < 4 ? 1 : 2));
		s.cy = rand_coord(mode < 2 ? 0 : (mode < 4 ? 1 : 2));
		s.cz = rand_coord(mode < 2 ? 0 : (mode < 4 ? 1 : 2));
		case ($urandom_range(9, 0))
			0:       s.rad = '0;
			1:       s.rad = RadW'($urandom);
			2:       s.rad = RadW'(RMAX - $urandom_range(3, 0));
			3, 4:    s.rad = RadW'($urandom_range(1500, 1));
			default: s.rad = RadW'($urandom_range(32'h0010_0000, 1));
		endcase
		return s;
	endfunction

	// receiver: random stalls, plus a long hold-off in its own phase
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (phase == PH_HOLD && hold_cycles > 0) begin
			res_ready   <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			res_ready <= !idle_now(1'b0);
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		held_t got, exp_h;
		if (arst_n && res_valid && res_ready) begin
			got = '{out_x, out_y, out_z, out_radius, out_valid};
			if (expected_spheres.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h z=%h r=%h v=%b",
					$time, out_x, out_y, out_z, out_radius, out_valid);
				errors++;
			end else begin
				exp_h = expected_spheres.pop_front();
				if (got !== exp_h) begin
					$display("%0t: mismatch expected x=%h y=%h z=%h r=%h v=%b",
						$time, exp_h.x, exp_h.y, exp_h.z, exp_h.r, exp_h.v);
					$display("%0t:          actual   x=%h y=%h z=%h r=%h v=%b",
						$time, got.x, got.y, got.z, got.r, got.v);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		sphere_t s;
		int n_sent;
		int drain;
		errors = 0;
		phase = PH_FREE;
		hold_cycles = 0;
		union_held = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_req = 1'b0;
		center_x = '0;
		center_y = '0;
		center_z = '0;
		sphere_radius = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table; typed results only where obvious
		rows.push_back('{'{1'b0, 0, 0, 0, 31'd0}, 1, '0});                 // nothing held
		rows.push_back('{'{1'b0, CMAX, CMIN, 0, RMAX}, 1, '{CMAX, CMIN, 0, RMAX, 1'b1}});
		rows.push_back('{'{1'b0, CMAX, CMIN, 0, 31'd1}, 1, '{CMAX, CMIN, 0, RMAX, 1'b1}});
		rows.push_back('{'{1'b1, 0, 0, 0, 31'd0}, 1, '0});                 // start, empty
		rows.push_back('{'{1'b0, CMIN, CMIN, CMIN, 31'd1}, 1, '{CMIN, CMIN, CMIN, 1, 1'b1}});
		rows.push_back('{'{1'b0, CMAX, CMAX, CMAX, 31'd1}, 0, '0});         // far growth
		rows.push_back('{'{1'b0, CMIN, CMAX, CMIN, RMAX}, 0, '0});          // saturation
		rows.push_back('{'{1'b1, 100, 200, 300, 31'd65536}, 1, '{100, 200, 300, 65536, 1'b1}});
		rows.push_back('{'{1'b0, 100, 200, 300, 31'd70000}, 1, '{100, 200, 300, 70000, 1'b1}});
		rows.push_back('{'{1'b0, 100, 200, 300, 31'd10}, 1, '{100, 200, 300, 70000, 1'b1}});
		rows.push_back('{'{1'b0, 200000, 200, 300, 31'd65536}, 0, '0});     // disjoint growth
		rows.push_back('{'{1'b0, -200000, -5000, 9000, 31'd3}, 0, '0});
		rows.push_back('{'{1'b0, 0, 0, 0, 31'd0}, 0, '0});                  // skipped
		rows.push_back('{'{1'b1, -1, -1, -1, 31'd5}, 1, '{-1, -1, -1, 5, 1'b1}});
		rows.push_back('{'{1'b0, 0, 0, 0, RMAX}, 0, '0});                   // swallows held
		rows.push_back('{'{1'b0, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678, 31'h2aaa_aaaa},
			0, '0});
		foreach (rows[i])
			send_sphere(rows[i].s, rows[i].fixed, rows[i].res);

		// random: mostly chains of growth, restarted now and then
		n_sent = 0;
		while (n_sent < 1400) begin
			phase = (n_sent / 140) % 4;
			if (n_sent == 700) begin
				// long receiver hold-off while the sender keeps offering
				phase = PH_HOLD;
				hold_cycles = 3000;
				repeat (12) begin
					send_sphere(rand_sphere($urandom_range(15, 0) == 0), 1'b0, '0);
					n_sent++;
				end
				phase = PH_FREE;
			end
			s = rand_sphere($urandom_range(24, 0) == 0);
			send_sphere(s, 1'b0, '0);
			n_sent++;
		end
		in_valid <= 1'b0;
		phase = PH_FREE;

		drain = 0;
		while (expected_spheres.size() != 0 && drain < 200000) begin
			@(posedge clk);
			drain++;
		end
		repeat (400) @(posedge clk);
		if (expected_spheres.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_spheres.size());
			errors++;
		end
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
